// ----- sv/cbt_pkg.sv -----
// Shared types and constants for the CSV byte tokenizer.
`default_nettype none
package cbt_pkg;

	// Limit on fields in one row and the counter width it needs
	localparam int MAX_FIELDS = 1024;
	localparam int FIELD_W    = $clog2(MAX_FIELDS + 1);
	localparam int LINE_W     = 24;

	// Special characters
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;

	// Kind of input beat
	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_EOF  = 1'b1;

	// Status codes
	typedef enum logic [2:0] {
		ST_OK              = 3'd0,
		ST_QUOTE_UNQUOTED  = 3'd1,
		ST_BAD_AFTER_QUOTE = 3'd2,
		ST_EMPTY_LINE      = 3'd3,
		ST_TOO_MANY        = 3'd4,
		ST_TOO_FEW         = 3'd5,
		ST_EOF_IN_QUOTE    = 3'd6,
		ST_COMPLETE        = 3'd7
	} status_t;

	// Input beat
	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} in_item_t;

	// Result beat
	typedef struct packed {
		logic [7:0]        out_byte;
		logic              byte_valid;
		logic              field_done;
		logic              row_done;
		logic [LINE_W-1:0] line_number;
		logic [2:0]        status;
	} out_item_t;

endpackage
`default_nettype wire

// ----- sv/cbt_ifs.sv -----
// Valid/ready channel interfaces for tokenizer input and result beats.
`default_nettype none
interface cbt_in_if;
	import cbt_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cbt_out_if;
	import cbt_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/csv_byte_tokenizer.sv -----
// CSV byte tokenizer: each input beat passes the input register, then parse logic
// into the result register, which holds the result beat.
// Throughput: one byte per cycle while the receiver does not stall the result register.
// A new beat is taken while a result waits, as long as the input register is free.
// Reset (arst_n low, asynchronous) returns to line start with all counts and
// the status cleared; no beat is lost or invented across stalls.
`default_nettype none
module csv_byte_tokenizer (
	input  wire logic clk,
	input  wire logic arst_n,
	cbt_in_if.sink    text,
	cbt_out_if.source tokens
);
	import cbt_pkg::*;

	typedef enum logic [4:0] {
		PH_LINE_START = 5'b00001,
		PH_FIELD_END  = 5'b00010,
		PH_PLAIN      = 5'b00100,
		PH_QUOTED     = 5'b01000,
		PH_QUOTE_SEEN = 5'b10000
	} phase_t;

	// Pipeline and state registers
	logic                valid_s1;
	in_item_t            item_s1;
	logic                out_valid_q;
	out_item_t           out_q;
	phase_t              phase_q;
	logic [FIELD_W-1:0]  fields_q;
	logic [FIELD_W-1:0]  expected_q;
	logic                spans_q;
	logic [LINE_W-1:0]   lines_q;
	status_t             status_q;

	// Next-state values
	phase_t              phase_n;
	logic [FIELD_W-1:0]  fields_n;
	logic [FIELD_W-1:0]  expected_n;
	logic                spans_n;
	logic [LINE_W-1:0]   lines_n;
	status_t             status_n;
	out_item_t           res;

	logic stall;
	logic advance;

	// Events decoded from the current byte
	logic               is_q;
	logic               is_c;
	logic               is_n;
	logic               at_start;
	logic               do_content;
	logic               do_close;
	logic               do_end;
	logic [FIELD_W-1:0] count_end;

	// Handshake: hold the input stage while the result register is blocked
	assign stall       = out_valid_q && !tokens.ready;
	assign advance     = valid_s1 && !stall;
	assign text.ready  = !valid_s1 || !stall;
	assign tokens.valid = out_valid_q;
	assign tokens.data  = out_q;

	assign is_q     = (item_s1.in_byte == CH_QUOTE);
	assign is_c     = (item_s1.in_byte == CH_COMMA);
	assign is_n     = (item_s1.in_byte == CH_NEWLINE);
	assign at_start = (phase_q == PH_LINE_START);

	// Parse one byte against the current state
	always_comb begin
		phase_n    = phase_q;
		fields_n   = fields_q;
		expected_n = expected_q;
		spans_n    = spans_q;
		lines_n    = lines_q;
		status_n   = status_q;
		do_content = 1'b0;
		do_close   = 1'b0;
		do_end     = 1'b0;
		count_end  = expected_q;
		res        = '0;

		if (status_q == ST_OK) begin
			if (item_s1.kind == KIND_EOF) begin
				if (spans_q && !at_start) begin
					status_n = ST_EOF_IN_QUOTE;
				end else begin
					status_n = ST_COMPLETE;
				end
			end else begin
				// Start a new line: count it and clear the row state
				if (at_start) begin
					if (lines_q != {LINE_W{1'b1}}) begin
						lines_n = lines_q + LINE_W'(1);
					end
					fields_n = '0;
					spans_n  = 1'b0;
				end

				unique case (phase_q)
					PH_LINE_START, PH_FIELD_END: begin
						if (is_q) begin
							phase_n = PH_QUOTED;
						end else if (is_c) begin
							do_close = 1'b1;
						end else if (is_n) begin
							if (at_start) begin
								status_n = ST_EMPTY_LINE;
							end else begin
								do_close = 1'b1;
								do_end   = 1'b1;
							end
						end else begin
							do_content = 1'b1;
							phase_n    = PH_PLAIN;
						end
					end
					PH_PLAIN: begin
						if (is_c) begin
							do_close = 1'b1;
						end else if (is_n) begin
							do_close = 1'b1;
							do_end   = 1'b1;
						end else if (is_q) begin
							status_n = ST_QUOTE_UNQUOTED;
						end else begin
							do_content = 1'b1;
						end
					end
					PH_QUOTED: begin
						if (is_q) begin
							phase_n = PH_QUOTE_SEEN;
						end else begin
							if (is_n) begin
								spans_n = 1'b1;
							end
							do_content = 1'b1;
						end
					end
					PH_QUOTE_SEEN: begin
						if (is_q) begin
							do_content = 1'b1;
							phase_n    = PH_QUOTED;
						end else if (is_c) begin
							do_close = 1'b1;
						end else if (is_n) begin
							do_close = 1'b1;
							do_end   = 1'b1;
						end else begin
							status_n = ST_BAD_AFTER_QUOTE;
						end
					end
					default: begin
						phase_n = PH_LINE_START;
					end
				endcase

				if (do_content) begin
					res.out_byte   = item_s1.in_byte;
					res.byte_valid = 1'b1;
				end

				// Close the field, guarding the row limit
				if (do_close) begin
					if (fields_n >= FIELD_W'(MAX_FIELDS)) begin
						status_n = ST_TOO_MANY;
					end else begin
						fields_n       = fields_n + FIELD_W'(1);
						res.field_done = 1'b1;
						phase_n        = PH_FIELD_END;
						// End the line: first line fixes the expected count
						if (do_end) begin
							if (expected_q == '0) begin
								count_end  = fields_n;
								expected_n = fields_n;
							end
							if (fields_n > count_end) begin
								status_n = ST_TOO_MANY;
							end else if (fields_n < count_end) begin
								status_n = ST_TOO_FEW;
							end else begin
								res.row_done = 1'b1;
								phase_n      = PH_LINE_START;
								fields_n     = '0;
								spans_n      = 1'b0;
							end
						end
					end
				end

				// Drop all marks on the byte that raises an error
				if (status_n != ST_OK) begin
					res.out_byte   = '0;
					res.byte_valid = 1'b0;
					res.field_done = 1'b0;
					res.row_done   = 1'b0;
				end
			end
		end

		res.line_number = lines_n;
		res.status      = status_n;
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			item_s1 <= text.data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	// Parser state: advance once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LINE_START;
			fields_q   <= '0;
			expected_q <= '0;
			spans_q    <= 1'b0;
			lines_q    <= '0;
			status_q   <= ST_OK;
		end else if (advance) begin
			phase_q    <= phase_n;
			fields_q   <= fields_n;
			expected_q <= expected_n;
			spans_q    <= spans_n;
			lines_q    <= lines_n;
			status_q   <= status_n;
		end
	end

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the CSV byte tokenizer: stimulus, prediction and checks.
`timescale 1ns / 100ps
module testbench;
	import cbt_pkg::*;

	localparam int ROW_FIELDS      = 3;
	localparam int IDLE_LIMIT      = 5000;
	localparam int REPORT_MAX      = 10;
	localparam int SEG_BEATS       = 230;
	localparam int SEG_BEATS_SHORT = 100;
	localparam int TERM_OVERFLOW   = 7;

	// Scanner phases of the expected-token predictor
	typedef enum logic [2:0] {
		AT_LINE_START,
		AFTER_FIELD,
		IN_PLAIN,
		IN_QUOTES,
		QUOTE_PENDING
	} phase_t;

	logic clk;
	logic arst_n;

	cbt_in_if  text_ch();
	cbt_out_if tok_ch();

	csv_byte_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.tokens (tok_ch)
	);

	// Predictor state
	phase_t             scan_phase;
	logic [FIELD_W-1:0] field_count;
	logic [FIELD_W-1:0] row_width;
	logic               row_multiline;
	logic [LINE_W-1:0]  line_count;
	status_t            doc_status;
	out_item_t          tok_pred;

	// Tokens still owed by the block, oldest first
	out_item_t tokens_due[$];
	out_item_t want;

	int idle_pct;
	int stall_pct;
	int mismatches;
	int idle_cycles;
	int beats_sent;
	int rows_accepted;
	int fields_closed;
	int quoted_sent;
	int term_case;
	int seg_beats;

	// Close the current field; flag overflow when the row is already full
	function automatic bit close_field();
		if (field_count >= MAX_FIELDS) begin
			doc_status = ST_TOO_MANY;
			return 1'b0;
		end
		field_count = field_count + 1'b1;
		tok_pred.field_done = 1'b1;
		scan_phase = AFTER_FIELD;
		return 1'b1;
	endfunction

	// Finish a line: the first line fixes the width, later ones must match it
	function automatic void end_row();
		if (row_width == '0)
			row_width = field_count;
		if (field_count > row_width) begin
			doc_status = ST_TOO_MANY;
			tok_pred.field_done = 1'b0;
		end else if (field_count < row_width) begin
			doc_status = ST_TOO_FEW;
			tok_pred.field_done = 1'b0;
		end else begin
			tok_pred.row_done = 1'b1;
			scan_phase = AT_LINE_START;
			field_count = '0;
			row_multiline = 1'b0;
		end
	endfunction

	// Handle the first byte of a field
	function automatic void open_field(logic [7:0] c, bit line_start);
		if (c == CH_QUOTE) begin
			scan_phase = IN_QUOTES;
		end else if (c == CH_COMMA) begin
			void'(close_field());
		end else if (c == CH_NEWLINE) begin
			if (line_start)
				doc_status = ST_EMPTY_LINE;
			else if (close_field())
				end_row();
		end else begin
			tok_pred.out_byte = c;
			tok_pred.byte_valid = 1'b1;
			scan_phase = IN_PLAIN;
		end
	endfunction

	// Advance the predictor by one input beat and return the token it owes
	function automatic out_item_t predict_token(in_item_t beat);
		logic [7:0] c;
		c = beat.in_byte;
		tok_pred = '0;
		if (doc_status == ST_OK) begin
			if (beat.kind == KIND_EOF) begin
				if (row_multiline && scan_phase != AT_LINE_START)
					doc_status = ST_EOF_IN_QUOTE;
				else
					doc_status = ST_COMPLETE;
			end else begin
				case (scan_phase)
					AT_LINE_START: begin
						if (line_count != '1)
							line_count = line_count + 1'b1;
						field_count = '0;
						row_multiline = 1'b0;
						open_field(c, 1'b1);
					end
					AFTER_FIELD: open_field(c, 1'b0);
					IN_PLAIN: begin
						if (c == CH_COMMA) begin
							void'(close_field());
						end else if (c == CH_NEWLINE) begin
							if (close_field())
								end_row();
						end else if (c == CH_QUOTE) begin
							doc_status = ST_QUOTE_UNQUOTED;
						end else begin
							tok_pred.out_byte = c;
							tok_pred.byte_valid = 1'b1;
						end
					end
					IN_QUOTES: begin
						if (c == CH_QUOTE) begin
							scan_phase = QUOTE_PENDING;
						end else begin
							if (c == CH_NEWLINE)
								row_multiline = 1'b1;
							tok_pred.out_byte = c;
							tok_pred.byte_valid = 1'b1;
						end
					end
					QUOTE_PENDING: begin
						if (c == CH_QUOTE) begin
							tok_pred.out_byte = c;
							tok_pred.byte_valid = 1'b1;
							scan_phase = IN_QUOTES;
						end else if (c == CH_COMMA) begin
							void'(close_field());
						end else if (c == CH_NEWLINE) begin
							if (close_field())
								end_row();
						end else begin
							doc_status = ST_BAD_AFTER_QUOTE;
						end
					end
					default: scan_phase = AT_LINE_START;
				endcase
				// Drop everything the error byte would have produced
				if (doc_status != ST_OK) begin
					tok_pred.out_byte = '0;
					tok_pred.byte_valid = 1'b0;
					tok_pred.field_done = 1'b0;
					tok_pred.row_done = 1'b0;
				end
			end
		end
		tok_pred.line_number = line_count;
		tok_pred.status = doc_status;
		return tok_pred;
	endfunction

	// Any byte that is not a comma, newline or quote
	function automatic logic [7:0] pick_plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_COMMA || b == CH_NEWLINE || b == CH_QUOTE);
		return b;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver stalls
	always @(negedge clk)
		tok_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

	// Check each result beat, then predict from each input beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (tok_ch.valid && tok_ch.ready) begin
				if (tokens_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: unexpected token byte=%02h v=%0b f=%0b r=%0b line=%0d st=%0d",
							$realtime, tok_ch.data.out_byte, tok_ch.data.byte_valid,
							tok_ch.data.field_done, tok_ch.data.row_done,
							tok_ch.data.line_number, tok_ch.data.status);
				end else begin
					want = tokens_due.pop_front();
					if (tok_ch.data.out_byte !== want.out_byte
							|| tok_ch.data.byte_valid !== want.byte_valid
							|| tok_ch.data.field_done !== want.field_done
							|| tok_ch.data.row_done !== want.row_done
							|| tok_ch.data.line_number !== want.line_number
							|| tok_ch.data.status !== want.status) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("%0t: token mismatch", $realtime);
							$display("  exp byte=%02h v=%0b f=%0b r=%0b line=%0d st=%0d",
								want.out_byte, want.byte_valid, want.field_done,
								want.row_done, want.line_number, want.status);
							$display("  got byte=%02h v=%0b f=%0b r=%0b line=%0d st=%0d",
								tok_ch.data.out_byte, tok_ch.data.byte_valid,
								tok_ch.data.field_done, tok_ch.data.row_done,
								tok_ch.data.line_number, tok_ch.data.status);
						end
					end
				end
			end
			if (text_ch.valid && text_ch.ready) begin
				tokens_due.insert(tokens_due.size(), predict_token(text_ch.data));
				if (tok_pred.row_done)
					rows_accepted++;
				if (tok_pred.field_done)
					fields_closed++;
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (tok_ch.valid && tok_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no beat moved in %0d cycles", IDLE_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Send one input beat; valid stays high for a following beat
	task automatic send_beat(input logic k, input logic [7:0] b);
		while ($urandom_range(0, 99) < idle_pct) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data  <= in_item_t'{kind: k, in_byte: b};
		do
			@(posedge clk);
		while (!(text_ch.valid && text_ch.ready));
		beats_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every owed token has arrived
	task automatic wait_drain();
		text_ch.valid <= 1'b0;
		@(negedge clk);
		while (tokens_due.size() != 0)
			@(negedge clk);
	endtask

	// Quoted field with random content; doubles quotes, optionally forces a newline
	task automatic send_quoted_field(input bit force_nl);
		int n;
		logic [7:0] b;
		quoted_sent++;
		send_beat(KIND_TEXT, CH_QUOTE);
		n = $urandom_range(0, 6);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0: b = CH_COMMA;
				1: b = CH_NEWLINE;
				2: b = CH_QUOTE;
				default: b = 8'($urandom_range(0, 255));
			endcase
			send_beat(KIND_TEXT, b);
			if (b == CH_QUOTE)
				send_beat(KIND_TEXT, CH_QUOTE);
		end
		if (force_nl)
			send_beat(KIND_TEXT, CH_NEWLINE);
		send_beat(KIND_TEXT, CH_QUOTE);
	endtask

	// One row of mixed empty, plain and quoted fields
	task automatic send_row(input int n_fields, input bit close_line, input bit force_nl);
		int i;
		int pick;
		for (i = 0; i < n_fields; i++) begin
			pick = $urandom_range(0, 99);
			if (i == 0 && force_nl)
				send_quoted_field(1'b1);
			else if (pick < 15)
				; // empty field: separator only
			else if (pick < 60)
				repeat ($urandom_range(1, 6))
					send_beat(KIND_TEXT, pick_plain_byte());
			else
				send_quoted_field(1'b0);
			if (i < n_fields - 1)
				send_beat(KIND_TEXT, CH_COMMA);
			else if (close_line)
				send_beat(KIND_TEXT, CH_NEWLINE);
		end
	endtask

	// Three fixed rows: extreme bytes, empty fields, doubled and quoted specials
	task automatic test_directed_rows();
		logic [7:0] script [25];
		int i;
		idle_pct  = 0;
		stall_pct = 0;
		script = '{
			8'h00, CH_COMMA, CH_COMMA, 8'hFF, CH_NEWLINE,
			CH_QUOTE, 8'h61, CH_QUOTE, CH_QUOTE, CH_QUOTE, CH_COMMA,
			CH_QUOTE, CH_COMMA, CH_QUOTE, CH_COMMA, CH_QUOTE, CH_QUOTE, CH_NEWLINE,
			CH_QUOTE, CH_NEWLINE, CH_QUOTE, CH_COMMA, 8'h78, CH_COMMA, CH_NEWLINE
		};
		for (i = 0; i < 25; i++)
			send_beat(KIND_TEXT, script[i]);
		wait_drain();
	endtask

	// Well-formed random rows, rotating through the idle and stall mixes
	task automatic test_random_rows();
		int seg;
		int start;
		for (seg = 0; seg < 8; seg++) begin
			case (seg % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 58; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 58; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase
			start = beats_sent;
			while (beats_sent - start < seg_beats)
				send_row(ROW_FIELDS, 1'b1, 1'b0);
			wait_drain();
		end
	endtask

	// End the document in the chosen way, clean or with an error
	task automatic test_termination();
		idle_pct  = 28;
		stall_pct = 28;
		case (term_case)
			0: send_beat(KIND_EOF, 8'($urandom_range(0, 255)));
			1: begin
				send_row(ROW_FIELDS, 1'b0, 1'b0);
				send_beat(KIND_EOF, 8'($urandom_range(0, 255)));
			end
			2: begin
				send_row(ROW_FIELDS, 1'b0, 1'b1);
				send_beat(KIND_EOF, 8'($urandom_range(0, 255)));
			end
			3: begin
				send_beat(KIND_TEXT, pick_plain_byte());
				send_beat(KIND_TEXT, CH_QUOTE);
			end
			4: begin
				send_beat(KIND_TEXT, CH_QUOTE);
				send_beat(KIND_TEXT, pick_plain_byte());
				send_beat(KIND_TEXT, CH_QUOTE);
				send_beat(KIND_TEXT, pick_plain_byte());
			end
			5: send_beat(KIND_TEXT, CH_NEWLINE);
			6: send_row(ROW_FIELDS + 1, 1'b1, 1'b0);
			TERM_OVERFLOW: repeat (MAX_FIELDS + 1)
				send_beat(KIND_TEXT, CH_COMMA);
			default: send_row(ROW_FIELDS - 1, 1'b1, 1'b0);
		endcase
	endtask

	// Random beats after the end: the status must hold and nothing else appear
	task automatic test_sticky_after_end();
		repeat (40)
			send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		send_beat(KIND_EOF, 8'hFF);
	endtask

	initial begin
		arst_n        = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.data  = '0;
		tok_ch.ready  = 1'b0;
		idle_pct      = 0;
		stall_pct     = 0;
		mismatches    = 0;
		idle_cycles   = 0;
		beats_sent    = 0;
		rows_accepted = 0;
		fields_closed = 0;
		quoted_sent   = 0;
		scan_phase    = AT_LINE_START;
		field_count   = '0;
		row_width     = '0;
		row_multiline = 1'b0;
		line_count    = '0;
		doc_status    = ST_OK;
		// Pick the ending up front; the long overflow ending shortens the random rows
		term_case     = $urandom_range(0, 8);
		seg_beats     = (term_case == TERM_OVERFLOW) ? SEG_BEATS_SHORT : SEG_BEATS;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_rows();
		test_random_rows();
		test_termination();
		test_sticky_after_end();

		// Let the last tokens come out, then a short settle
		wait_drain();
		repeat (20) @(negedge clk);

		$display("covered %0d input beats: %0d rows accepted, %0d fields closed, %0d quoted",
			beats_sent, rows_accepted, fields_closed, quoted_sent);
		$display("document ended with %s after %0d lines, %0d mismatches",
			doc_status.name(), line_count, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
